// ===== hw/rtl/lav_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg
// Widths, latencies, payload types and the saturation helper of the
// look-at view matrix builder.
// ----------------------------------------------------------------------------
package lav_pkg;

	localparam int WORD_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	localparam int MAG_W      = (WORD_WIDTH + 1 > 2 * FRAC_BITS + 2) ?
	                            WORD_WIDTH + 1 : 2 * FRAC_BITS + 2;
	localparam int VEC_W      = MAG_W + 1;
	localparam int NORM_W     = 31;
	localparam int SHIFT_W    = (MAG_W > NORM_W) ? MAG_W : NORM_W;
	localparam int LEN_W      = $clog2(SHIFT_W + 1);
	localparam int SQ_W       = 2 * NORM_W + 2;
	localparam int ROOT_STEPS = SQ_W / 2;
	localparam int ROOT_W     = NORM_W + 1;
	localparam int DIV_W      = ROOT_W + FRAC_BITS;
	localparam int DIV_STEPS  = FRAC_BITS + 1;
	localparam int QUO_W      = FRAC_BITS + 1;
	localparam int UNIT_W     = FRAC_BITS + 2;
	localparam int UNIT_LAT   = ROOT_STEPS + DIV_STEPS + 7;
	localparam int CP_W       = 2 * UNIT_W;
	localparam int PROD_W     = UNIT_W + WORD_WIDTH;
	localparam int DOT_W      = PROD_W + 2;
	localparam int EXT_W      = PROD_W + 4;
	localparam int FR_DLY     = UNIT_LAT + 2;
	localparam int EYE_DLY    = 2 * UNIT_LAT + 2;
	localparam int PIPE_LAT   = 2 * UNIT_LAT + 6;
	localparam int COL_W      = 2;

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(3);

	localparam int VEC_R = 0;
	localparam int VEC_U = 1;
	localparam int VEC_F = 2;

	typedef logic signed [WORD_WIDTH-1:0] word_t;
	typedef logic signed [VEC_W-1:0]      vcomp_t;
	typedef logic signed [UNIT_W-1:0]     unit_t;

	typedef struct packed {
		word_t eye_x;
		word_t eye_y;
		word_t eye_z;
		word_t target_x;
		word_t target_y;
		word_t target_z;
	} in_item_t;

	typedef struct packed {
		logic [COL_W-1:0] column_index;
		word_t            row_zero;
		word_t            row_one;
		word_t            row_two;
		word_t            row_three;
		logic             degenerate;
		logic             last_column;
	} out_item_t;

	function automatic word_t sat_word(input logic signed [EXT_W-1:0] x);
		logic [EXT_W-WORD_WIDTH:0] hi_bits;
		hi_bits = x[EXT_W-1:WORD_WIDTH-1];
		if (hi_bits == '0 || hi_bits == '1)
			sat_word = x[WORD_WIDTH-1:0];
		else if (x[EXT_W-1])
			sat_word = {1'b1, {(WORD_WIDTH-1){1'b0}}};
		else
			sat_word = {1'b0, {(WORD_WIDTH-1){1'b1}}};
	endfunction

	localparam word_t ONE_SAT = sat_word(EXT_W'(1) << FRAC_BITS);

endpackage

// ===== hw/rtl/lav_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_in_if
// Input channel: one eye position and target point per item.
// ----------------------------------------------------------------------------
interface lav_in_if;
	import lav_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/lav_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_out_if
// Output channel: one matrix column per item.
// ----------------------------------------------------------------------------
interface lav_out_if;
	import lav_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/lav_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_unit
// Pipelined 3-vector normalizer: magnitude scaling, squares, bit-per-stage
// square root, bit-per-stage rounded division.
// ----------------------------------------------------------------------------
module lav_unit (
	input  logic            clk,
	input  logic            adv,
	input  lav_pkg::vcomp_t vin [3],
	output lav_pkg::unit_t  uout [3],
	output logic            zero
);
	import lav_pkg::*;

	logic signed [VEC_W-1:0]  nv [3];
	logic [MAG_W-1:0]         mag_s1 [3];
	logic [2:0]               sgn_s1;
	logic [MAG_W-1:0]         mor;
	logic [LEN_W-1:0]         len_c;
	logic [MAG_W-1:0]         mag_s2 [3];
	logic [2:0]               sgn_s2;
	logic [LEN_W-1:0]         len_s2;
	logic                     zero_s2;
	logic [SHIFT_W-1:0]       wide [3];
	logic [SHIFT_W-1:0]       shd [3];
	logic [NORM_W-1:0]        nm_s3 [3];
	logic [2:0]               sgn_s3;
	logic                     zero_s3;
	logic [2*NORM_W-1:0]      sq_s4 [3];
	logic [NORM_W-1:0]        nm_s4 [3];
	logic [2:0]               sgn_s4;
	logic                     zero_s4;

	logic [SQ_W-1:0]          rn [0:ROOT_STEPS];
	logic [SQ_W-1:0]          rr [0:ROOT_STEPS];
	logic [NORM_W-1:0]        rt_nm [0:ROOT_STEPS][3];
	logic [2:0]               rt_sgn [0:ROOT_STEPS];
	logic                     rt_zero [0:ROOT_STEPS];

	logic [DIV_W-1:0]         dr [0:DIV_STEPS][3];
	logic [QUO_W-1:0]         dq [0:DIV_STEPS][3];
	logic [ROOT_W-1:0]        ds [0:DIV_STEPS];
	logic [2:0]               dsgn [0:DIV_STEPS];
	logic                     dzero [0:DIV_STEPS];
	logic [ROOT_W-1:0]        root;

	always_comb begin
		for (int i = 0; i < 3; i++)
			nv[i] = -vin[i];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sgn_s1[i] <= vin[i][VEC_W-1];
				mag_s1[i] <= vin[i][VEC_W-1] ? nv[i][MAG_W-1:0] : vin[i][MAG_W-1:0];
			end
		end
	end

	// bit length of the largest magnitude equals that of the OR
	always_comb begin
		mor   = mag_s1[0] | mag_s1[1] | mag_s1[2];
		len_c = '0;
		for (int b = 0; b < MAG_W; b++)
			if (mor[b])
				len_c = LEN_W'(b + 1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2  <= mag_s1;
			sgn_s2  <= sgn_s1;
			len_s2  <= len_c;
			zero_s2 <= (mor == '0);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide[i] = SHIFT_W'(mag_s2[i]);
			if (len_s2 > LEN_W'(NORM_W))
				shd[i] = wide[i] >> (len_s2 - LEN_W'(NORM_W));
			else
				shd[i] = wide[i] << (LEN_W'(NORM_W) - len_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				nm_s3[i] <= shd[i][NORM_W-1:0];
			sgn_s3  <= sgn_s2;
			zero_s3 <= zero_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				sq_s4[i] <= nm_s3[i] * nm_s3[i];
			nm_s4   <= nm_s3;
			sgn_s4  <= sgn_s3;
			zero_s4 <= zero_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rn[0]      <= SQ_W'(sq_s4[0]) + SQ_W'(sq_s4[1]) + SQ_W'(sq_s4[2]);
			rr[0]      <= '0;
			rt_nm[0]   <= nm_s4;
			rt_sgn[0]  <= sgn_s4;
			rt_zero[0] <= zero_s4;
		end
	end

	for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
		logic [SQ_W-1:0] rbit;
		logic [SQ_W-1:0] trial;
		logic            ge;

		assign rbit  = SQ_W'(1) << (SQ_W - 2 - 2 * j);
		assign trial = rr[j] + rbit;
		assign ge    = (rn[j] >= trial);

		always_ff @(posedge clk) begin
			if (adv) begin
				rn[j+1]      <= ge ? rn[j] - trial : rn[j];
				rr[j+1]      <= ge ? (rr[j] >> 1) + rbit : rr[j] >> 1;
				rt_nm[j+1]   <= rt_nm[j];
				rt_sgn[j+1]  <= rt_sgn[j];
				rt_zero[j+1] <= rt_zero[j];
			end
		end
	end

	assign root = rr[ROOT_STEPS][ROOT_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dr[0][i] <= (DIV_W'(rt_nm[ROOT_STEPS][i]) << FRAC_BITS) + DIV_W'(root >> 1);
				dq[0][i] <= '0;
			end
			ds[0]    <= root;
			dsgn[0]  <= rt_sgn[ROOT_STEPS];
			dzero[0] <= rt_zero[ROOT_STEPS];
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [DIV_W-1:0] cmp;

		assign cmp = DIV_W'(ds[k]) << (FRAC_BITS - k);

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < 3; i++) begin
					if (dr[k][i] >= cmp) begin
						dr[k+1][i] <= dr[k][i] - cmp;
						dq[k+1][i] <= dq[k][i] | (QUO_W'(1) << (FRAC_BITS - k));
					end else begin
						dr[k+1][i] <= dr[k][i];
						dq[k+1][i] <= dq[k][i];
					end
				end
				ds[k+1]    <= ds[k];
				dsgn[k+1]  <= dsgn[k];
				dzero[k+1] <= dzero[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (dzero[DIV_STEPS])
					uout[i] <= '0;
				else if (dsgn[DIV_STEPS][i])
					uout[i] <= -UNIT_W'(dq[DIV_STEPS][i]);
				else
					uout[i] <= UNIT_W'(dq[DIV_STEPS][i]);
			end
			zero <= dzero[DIV_STEPS];
		end
	end

endmodule

// ===== hw/rtl/look_at_view_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Builds a column-major 4x4 look-at view matrix from eye and target points,
// Q16.16, emitting one column per output item.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  point    in   valid/ready    eye_x..z, target_x..z
//  column   out  valid/ready    column_index, rows 0..3, degenerate, last_column
//
//  Pipeline of PIPE_LAT stages (2*UNIT_LAT+6, 118 at Q16.16); one input item
//  yields four column items, so the column register, not the pipe, bounds the
//  input rate. A new input item may enter in any cycle the pipe advances.
//  Reset clears the valid chain and the column register. When the column
//  register is busy and the last stage holds an item, the pipe holds.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
	input  logic      clk,
	input  logic      arst_n,
	lav_in_if.sink    point,
	lav_out_if.source column
);
	import lav_pkg::*;

	logic                      adv;
	logic                      load;
	logic [PIPE_LAT:1]         vld_q;

	vcomp_t                    d_s1 [3];
	vcomp_t                    h_s1 [3];
	word_t                     eye_s1 [3];

	unit_t                     f_u [3];
	unit_t                     r_u [3];
	unit_t                     u_u [3];
	logic                      zf;
	logic                      zr;
	logic                      zu;

	logic signed [CP_W-1:0]    p_r1f2_s2, p_r0f2_s2, p_r0f1_s2, p_r1f0_s2;
	vcomp_t                    w_s3 [3];

	unit_t                     f_dly_q [0:FR_DLY-1][3];
	unit_t                     r_dly_q [0:FR_DLY-1][3];
	logic                      bad_dly_q [0:FR_DLY-1];
	word_t                     eye_dly_q [0:EYE_DLY-1][3];

	logic                      bad_c;
	unit_t                     um_c [3][3];
	unit_t                     un_s4 [3][3];
	logic signed [PROD_W-1:0]  pr_s4 [3][3];
	logic                      bad_s4;
	logic signed [DOT_W-1:0]   acc [3];
	logic signed [DOT_W-1:0]   dot_s5 [3];
	unit_t                     un_s5 [3][3];
	logic                      bad_s5;
	word_t                     mat_c [4][3];
	word_t                     mat_s6 [4][3];
	logic                      bad_s6;

	word_t                     mat_q [4][3];
	logic                      deg_q;
	logic [COL_W-1:0]          col_q;
	logic                      full_q;

	assign load        = vld_q[PIPE_LAT] && (!full_q || (column.ready && col_q == LAST_COL));
	assign adv         = !vld_q[PIPE_LAT] || load;
	assign point.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[PIPE_LAT-1:1], point.valid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0]   <= VEC_W'(point.payload.target_x) - VEC_W'(point.payload.eye_x);
			d_s1[1]   <= VEC_W'(point.payload.target_y) - VEC_W'(point.payload.eye_y);
			d_s1[2]   <= VEC_W'(point.payload.target_z) - VEC_W'(point.payload.eye_z);
			h_s1[0]   <= VEC_W'(point.payload.target_y) - VEC_W'(point.payload.eye_y);
			h_s1[1]   <= VEC_W'(point.payload.eye_x) - VEC_W'(point.payload.target_x);
			h_s1[2]   <= '0;
			eye_s1[0] <= point.payload.eye_x;
			eye_s1[1] <= point.payload.eye_y;
			eye_s1[2] <= point.payload.eye_z;
		end
	end

	lav_unit u_fwd (.clk(clk), .adv(adv), .vin(d_s1), .uout(f_u), .zero(zf));
	lav_unit u_rgt (.clk(clk), .adv(adv), .vin(h_s1), .uout(r_u), .zero(zr));

	always_ff @(posedge clk) begin
		if (adv) begin
			p_r1f2_s2 <= r_u[1] * f_u[2];
			p_r0f2_s2 <= r_u[0] * f_u[2];
			p_r0f1_s2 <= r_u[0] * f_u[1];
			p_r1f0_s2 <= r_u[1] * f_u[0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s3[0] <= VEC_W'(p_r1f2_s2);
			w_s3[1] <= -VEC_W'(p_r0f2_s2);
			w_s3[2] <= VEC_W'(p_r0f1_s2) - VEC_W'(p_r1f0_s2);
		end
	end

	lav_unit u_up (.clk(clk), .adv(adv), .vin(w_s3), .uout(u_u), .zero(zu));

	always_ff @(posedge clk) begin
		if (adv) begin
			f_dly_q[0]   <= f_u;
			r_dly_q[0]   <= r_u;
			bad_dly_q[0] <= zf | zr;
			for (int k = 1; k < FR_DLY; k++) begin
				f_dly_q[k]   <= f_dly_q[k-1];
				r_dly_q[k]   <= r_dly_q[k-1];
				bad_dly_q[k] <= bad_dly_q[k-1];
			end
			eye_dly_q[0] <= eye_s1;
			for (int k = 1; k < EYE_DLY; k++)
				eye_dly_q[k] <= eye_dly_q[k-1];
		end
	end

	// drop all vectors of a degenerate item
	always_comb begin
		bad_c = bad_dly_q[FR_DLY-1] | zu;
		for (int i = 0; i < 3; i++) begin
			um_c[VEC_R][i] = bad_c ? '0 : r_dly_q[FR_DLY-1][i];
			um_c[VEC_U][i] = bad_c ? '0 : u_u[i];
			um_c[VEC_F][i] = bad_c ? '0 : f_dly_q[FR_DLY-1][i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int v = 0; v < 3; v++)
				for (int i = 0; i < 3; i++)
					pr_s4[v][i] <= um_c[v][i] * eye_dly_q[EYE_DLY-1][i];
			un_s4  <= um_c;
			bad_s4 <= bad_c;
		end
	end

	always_comb begin
		for (int v = 0; v < 3; v++)
			acc[v] = DOT_W'(pr_s4[v][0]) + DOT_W'(pr_s4[v][1]) + DOT_W'(pr_s4[v][2])
			         + (DOT_W'(1) << (FRAC_BITS - 1));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int v = 0; v < 3; v++)
				dot_s5[v] <= acc[v] >>> FRAC_BITS;
			un_s5  <= un_s4;
			bad_s5 <= bad_s4;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mat_c[k][0] = sat_word(EXT_W'(un_s5[VEC_R][k]));
			mat_c[k][1] = sat_word(EXT_W'(un_s5[VEC_U][k]));
			mat_c[k][2] = sat_word(-EXT_W'(un_s5[VEC_F][k]));
		end
		mat_c[3][0] = sat_word(-EXT_W'(dot_s5[VEC_R]));
		mat_c[3][1] = sat_word(-EXT_W'(dot_s5[VEC_U]));
		mat_c[3][2] = sat_word(EXT_W'(dot_s5[VEC_F]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mat_s6 <= mat_c;
			bad_s6 <= bad_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			col_q  <= '0;
		end else if (load) begin
			full_q <= 1'b1;
			col_q  <= '0;
		end else if (full_q && column.ready) begin
			col_q <= col_q + COL_W'(1);
			if (col_q == LAST_COL)
				full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mat_q <= mat_s6;
			deg_q <= bad_s6;
		end
	end

	assign column.valid = full_q;

	always_comb begin
		column.payload.column_index = col_q;
		column.payload.row_zero     = mat_q[col_q][0];
		column.payload.row_one      = mat_q[col_q][1];
		column.payload.row_two      = mat_q[col_q][2];
		column.payload.row_three    = (col_q == LAST_COL) ? ONE_SAT : '0;
		column.payload.degenerate   = deg_q;
		column.payload.last_column  = (col_q == LAST_COL);
	end

endmodule
